// ===== rtl/ipwc_pkg.sv =====
// ============================================================================
// ipwc_pkg
// Shared item types, operation and result codes for the IR pulse-width capture.
// ============================================================================
`default_nettype none

package ipwc_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_EDGE = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_OK       = 2'd0;
    localparam logic [1:0] KIND_LEN_ERR  = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;
    localparam logic [1:0] KIND_READ     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TICK_STEP   = 2'd0;
    localparam logic [1:0] CFG_FINISH_TIME = 2'd1;
    localparam logic [1:0] CFG_MIN_PULSES  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int ELAPSED_W = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    localparam logic [7:0]  TICK_STEP_RST   = 8'd50;
    localparam logic [15:0] FINISH_TIME_RST = 16'd10000;
    localparam logic [9:0]  MIN_PULSES_RST  = 10'd10;

    typedef struct packed {
        logic [1:0] op;
        logic [8:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  pulse_count;
        logic [15:0] width_value;
    } out_item_t;

    // result leaving the control stage, width still to come from the store
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [9:0]  pulse_count;
        logic        zero_width;
    } res_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'b001,
        MODE_ARMED    = 3'b010,
        MODE_DECODING = 3'b100
    } mode_t;

endpackage

`default_nettype wire

// ===== rtl/ipwc_store.sv =====
// ============================================================================
// ipwc_store
// Pulse-width memory: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module ipwc_store
#(
    parameter int STORE_DEPTH = 512
)
(
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
    input  wire logic [15:0]                    wr_data,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
    output logic      [15:0]                    rd_data
);

    logic [15:0] mem [STORE_DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/ipwc_ctrl.sv =====
// ============================================================================
// ipwc_ctrl
// Capture sequencer: config registers, mode, elapsed timer, pulse count.
// ============================================================================
`default_nettype none

module ipwc_ctrl
    import ipwc_pkg::*;
#(
    parameter int STORE_DEPTH = 512
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_data,
    input  wire logic                           acc,
    input  wire in_item_t                       item,
    output res_t                                res,
    output logic                                wr_en,
    output logic      [$clog2(STORE_DEPTH)-1:0] wr_addr,
    output logic      [15:0]                    wr_data,
    output logic                                rd_en,
    output logic      [$clog2(STORE_DEPTH)-1:0] rd_addr
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int IW = (AW > 9) ? AW : 9;

    logic [7:0]           tick_step_reg;
    logic [15:0]          finish_time_reg;
    logic [9:0]           min_pulses_reg;
    mode_t                mode_reg,    mode_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [CW-1:0]        count_reg,   count_next;

    logic [ELAPSED_W:0]   tick_sum;
    logic [ELAPSED_W-1:0] tick_sat;
    logic [15:0]          count_wide;
    logic [15:0]          index_wide;
    logic [IW-1:0]        index_ext;
    logic                 store_full;
    logic                 index_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg   <= TICK_STEP_RST;
            finish_time_reg <= FINISH_TIME_RST;
            min_pulses_reg  <= MIN_PULSES_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TICK_STEP:   tick_step_reg   <= cfg_data[7:0];
                CFG_FINISH_TIME: finish_time_reg <= cfg_data;
                CFG_MIN_PULSES:  min_pulses_reg  <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    assign tick_sum   = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(tick_step_reg);
    assign tick_sat   = tick_sum[ELAPSED_W] ? ELAPSED_MAX : tick_sum[ELAPSED_W-1:0];
    assign count_wide = 16'(count_reg);
    assign index_wide = 16'(item.read_index);
    assign index_ext  = IW'(item.read_index);
    assign store_full = (count_reg == CW'(STORE_DEPTH));
    assign index_hit  = (index_wide < count_wide);

    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = elapsed_reg[15:0];
    assign rd_addr = index_ext[AW-1:0];

    always_comb
    begin
        mode_next        = mode_reg;
        elapsed_next     = elapsed_reg;
        count_next       = count_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        res.valid        = 1'b0;
        res.kind         = KIND_READ;
        res.pulse_count  = count_wide[9:0];
        res.zero_width   = 1'b1;
        if (acc)
        begin
            unique case (item.op)
                OP_ARM:
                begin
                    count_next = '0;
                    mode_next  = MODE_ARMED;
                end
                OP_TICK:
                begin
                    if (mode_reg == MODE_DECODING)
                    begin
                        elapsed_next = tick_sat;
                        if (tick_sat >= ELAPSED_W'(finish_time_reg))
                        begin
                            mode_next = MODE_IDLE;
                            res.valid = 1'b1;
                            res.kind  = ((count_wide > 16'(min_pulses_reg)) && !store_full)
                                        ? KIND_OK : KIND_LEN_ERR;
                        end
                    end
                end
                OP_EDGE:
                begin
                    unique case (mode_reg)
                        MODE_IDLE:  ;
                        MODE_ARMED:
                        begin
                            elapsed_next = '0;
                            count_next   = '0;
                            mode_next    = MODE_DECODING;
                        end
                        MODE_DECODING:
                        begin
                            if (!store_full)
                            begin
                                wr_en        = 1'b1;
                                elapsed_next = '0;
                                count_next   = count_reg + CW'(1);
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                                res.valid = 1'b1;
                                res.kind  = KIND_OVERFLOW;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_READ:
                begin
                    res.valid      = 1'b1;
                    res.kind       = KIND_READ;
                    res.zero_width = !index_hit;
                    rd_en          = index_hit;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            elapsed_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ipwc_out.sv =====
// ============================================================================
// ipwc_out
// Result stage: waits for store read data, then holds the item for the sink.
// ============================================================================
`default_nettype none

module ipwc_out
    import ipwc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire res_t        res,
    input  wire logic [15:0] rd_data,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_item
);

    logic      s1_valid_reg,  s1_valid_next;
    res_t      s1_res_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    logic      advance;
    logic      load;

    // the result register frees up when empty or taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    // the read stage takes a new item when empty or when it moves on
    assign load     = !s1_valid_reg || advance;
    assign in_stall = !load;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (load)
        begin
            s1_valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_res_reg <= res;
        end
        if (advance)
        begin
            out_item_reg.kind        <= s1_res_reg.kind;
            out_item_reg.pulse_count <= s1_res_reg.pulse_count;
            out_item_reg.width_value <= s1_res_reg.zero_width ? 16'd0 : rd_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/ir_pulse_width_capture_top.sv =====
// ============================================================================
// ir_pulse_width_capture_top
// Raw IR capture: times gaps between receiver edges into a pulse-width store.
// ============================================================================
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  in        | in_valid / in_stall    | in_item  (op, read_index)
//  out       | out_valid / out_stall  | out_item (kind, pulse_count, width_value)
//  cfg       | cfg_wr_en              | cfg_index, cfg_data (write only)
//
//  Throughput is one item per clock while in_stall is low; any update of
//  mode/elapsed/count by an op (arm, tick, edge, read) is made in the cycle it is accepted.
//  A result enters the read stage (and the store's registered read port)
//  when its item is accepted, then moves on to the output register, which
//  drives out_valid, once that register is empty or being taken; the sink
//  takes it from there.
//  in_stall rises only when both the read stage and the output register
//  hold a result and out_stall is high.
//  Reset is asynchronous; there is no clearing pass. Store entries are only
//  read below the current count, which this capture has already written.
//
`default_nettype none

module ir_pulse_width_capture_top
    import ipwc_pkg::*;
#(
    parameter int STORE_DEPTH = 512
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    // result items
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item,
    // register writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic          acc;
    res_t          res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    assign acc = in_valid && !in_stall;

    // sequencer: decides each item's effect and result kind at accept
    ipwc_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (acc),
        .item      (in_item),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // width store; a write and a read never hit in the same item
    ipwc_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // read stage plus output register (acts as the skid)
    ipwc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .rd_data   (rd_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/ipwc_checker.sv =====
// ============================================================================
// ipwc_checker
// Port-level checks for the IR pulse-width capture block.
// ============================================================================
`default_nettype none

module ipwc_port_checker
    import ipwc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_stall,
    input  wire in_item_t  in_item,
    input  wire logic      out_valid,
    input  wire logic      out_stall,
    input  wire out_item_t out_item
);

    // capture results always carry a zero width
    a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind != KIND_READ) |-> out_item.width_value == 16'd0)
        else $error("non-read result with nonzero width");

    // backpressure is the only cause of input stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a new result always comes from an accepted item, via the read stage and the output register
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without an accepted item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

endmodule

bind ir_pulse_width_capture_top ipwc_port_checker u_ipwc_checker (.*);

`default_nettype wire
